// ----- sv/pidl_pkg.sv -----
package pidl_pkg;

  localparam int unsigned CAPACITY_DEF   = 16;
  localparam int unsigned DATA_WIDTH_DEF = 32;

  localparam int unsigned CMD_W  = 3;
  localparam int unsigned POS_W  = 5;
  localparam int unsigned VAL_W  = 32;
  localparam int unsigned STAT_W = 3;
  localparam int unsigned ELEM_W = 32;
  localparam int unsigned CNTF_W = 5;

  localparam logic [CMD_W-1:0] CMD_INS_TAIL = 3'd0;
  localparam logic [CMD_W-1:0] CMD_INS_HEAD = 3'd1;
  localparam logic [CMD_W-1:0] CMD_INS_POS  = 3'd2;
  localparam logic [CMD_W-1:0] CMD_DEL_TAIL = 3'd3;
  localparam logic [CMD_W-1:0] CMD_DEL_HEAD = 3'd4;
  localparam logic [CMD_W-1:0] CMD_DEL_POS  = 3'd5;
  localparam logic [CMD_W-1:0] CMD_DISPLAY  = 3'd6;

  localparam logic [STAT_W-1:0] ST_OK         = 3'd0;
  localparam logic [STAT_W-1:0] ST_FULL       = 3'd1;
  localparam logic [STAT_W-1:0] ST_EMPTY      = 3'd2;
  localparam logic [STAT_W-1:0] ST_POS_ZERO   = 3'd3;
  localparam logic [STAT_W-1:0] ST_POS_BEYOND = 3'd4;

  typedef struct packed {
    logic [CMD_W-1:0]        command;
    logic [POS_W-1:0]        position;
    logic signed [VAL_W-1:0] value;
  } pidl_in_t;

  typedef struct packed {
    logic [STAT_W-1:0]        status;
    logic signed [ELEM_W-1:0] element;
    logic [CNTF_W-1:0]        count;
    logic                     last;
  } pidl_out_t;

  // controller to datapath
  typedef struct packed {
    logic exec;
    logic disp_start;
    logic disp_step;
  } pidl_ctl_t;

  // datapath to controller
  typedef struct packed {
    logic empty;
    logic disp_last;
  } pidl_sts_t;

endpackage

// ----- sv/pidl_ctrl.sv -----
module pidl_ctrl import pidl_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start,
  input  logic [CMD_W-1:0]     command_i,
  input  pidl_sts_t            sts_i,
  output logic                 busy,
  output pidl_ctl_t            ctl_o
);

  typedef enum logic {
    S_IDLE,
    S_DISP
  } state_e;

  state_e state_q, state_d;
  logic   accept;

  assign busy   = (state_q == S_DISP);
  assign accept = start && !busy;

  always_comb begin
    state_d = state_q;
    ctl_o   = '0;
    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          if (command_i == CMD_DISPLAY && !sts_i.empty) begin
            ctl_o.disp_start = 1'b1;
            state_d          = S_DISP;
          end else begin
            ctl_o.exec = 1'b1;
          end
        end
      end
      S_DISP: begin
        ctl_o.disp_step = 1'b1;
        if (sts_i.disp_last) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// ----- sv/pidl_datapath.sv -----
module pidl_datapath import pidl_pkg::*; #(
  parameter int unsigned CAPACITY   = CAPACITY_DEF,
  parameter int unsigned DATA_WIDTH = DATA_WIDTH_DEF
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  pidl_in_t  cmd_i,
  input  pidl_ctl_t ctl_i,
  output pidl_sts_t sts_o,
  output logic      res_valid_o,
  output pidl_out_t res_o
);

  localparam int unsigned CntW = $clog2(CAPACITY + 1);
  localparam int unsigned IdxW = $clog2(CAPACITY);

  logic signed [DATA_WIDTH-1:0] cells_q [CAPACITY];
  logic signed [DATA_WIDTH-1:0] cells_d [CAPACITY];
  logic [CntW-1:0]              cnt_q, cnt_d;
  logic [IdxW-1:0]              idx_q, idx_d;
  logic                         valid_q;
  pidl_out_t                    res_q, res_d;

  logic                         full, empty, disp_last;
  logic [CntW-1:0]              pos_c, pos_m1, cnt_m1;
  logic                         pos_beyond, pos_zero;
  logic                         is_ins, is_del, do_ins, do_del;
  logic [CntW-1:0]              ins_idx, del_idx;
  logic [STAT_W-1:0]            status;
  logic signed [DATA_WIDTH-1:0] val;

  assign full       = (cnt_q == CntW'(CAPACITY));
  assign empty      = (cnt_q == '0);
  assign cnt_m1     = cnt_q - 1'b1;
  assign disp_last  = (CntW'(idx_q) == cnt_m1);
  assign pos_c      = CntW'(cmd_i.position);
  assign pos_m1     = pos_c - 1'b1;
  assign pos_beyond = (32'(cmd_i.position) > 32'(cnt_q));
  assign pos_zero   = (cmd_i.position == '0);
  assign val        = DATA_WIDTH'(cmd_i.value);

  assign sts_o.empty     = empty;
  assign sts_o.disp_last = disp_last;

  // command decode and checks
  always_comb begin
    status  = ST_OK;
    is_ins  = 1'b0;
    is_del  = 1'b0;
    ins_idx = cnt_q;
    del_idx = cnt_m1;
    unique case (cmd_i.command)
      CMD_INS_TAIL, CMD_INS_HEAD, CMD_INS_POS: begin
        is_ins = 1'b1;
        if (full) begin
          status = ST_FULL;
        end else if (cmd_i.command == CMD_INS_POS) begin
          if (pos_beyond)    status = ST_POS_BEYOND;
          else if (pos_zero) status = ST_POS_ZERO;
        end
        if (cmd_i.command == CMD_INS_HEAD)     ins_idx = '0;
        else if (cmd_i.command == CMD_INS_POS) ins_idx = pos_m1;
      end
      CMD_DEL_TAIL, CMD_DEL_HEAD, CMD_DEL_POS: begin
        is_del = 1'b1;
        if (empty) begin
          status = ST_EMPTY;
        end else if (cmd_i.command == CMD_DEL_POS) begin
          if (pos_beyond)    status = ST_POS_BEYOND;
          else if (pos_zero) status = ST_POS_ZERO;
        end
        if (cmd_i.command == CMD_DEL_HEAD)     del_idx = '0;
        else if (cmd_i.command == CMD_DEL_POS) del_idx = pos_m1;
      end
      default: ;
    endcase
  end

  assign do_ins = ctl_i.exec && is_ins && (status == ST_OK);
  assign do_del = ctl_i.exec && is_del && (status == ST_OK);

  // every cell picks from itself, a neighbor, the new value or the head cell
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    localparam logic [CntW-1:0] I = CntW'(i);
    always_comb begin
      cells_d[i] = cells_q[i];
      if (do_ins) begin
        if (I == ins_idx) begin
          cells_d[i] = val;
        end else if (I > ins_idx) begin
          cells_d[i] = cells_q[(i > 0) ? i - 1 : 0];
        end
      end else if (do_del) begin
        if (I >= del_idx && i < CAPACITY - 1) begin
          cells_d[i] = cells_q[(i < CAPACITY - 1) ? i + 1 : i];
        end
      end else if (ctl_i.disp_step) begin
        // rotate the occupied part so the head word comes out each cycle
        if (I == cnt_m1) begin
          cells_d[i] = cells_q[0];
        end else if (I < cnt_m1) begin
          cells_d[i] = cells_q[(i < CAPACITY - 1) ? i + 1 : i];
        end
      end
    end
  end

  always_comb begin
    cnt_d = cnt_q;
    if (do_ins)      cnt_d = cnt_q + 1'b1;
    else if (do_del) cnt_d = cnt_m1;
  end

  always_comb begin
    idx_d = idx_q;
    if (ctl_i.disp_start) begin
      idx_d = '0;
    end else if (ctl_i.disp_step) begin
      idx_d = disp_last ? '0 : idx_q + 1'b1;
    end
  end

  always_comb begin
    res_d         = res_q;
    res_d.status  = status;
    res_d.element = '0;
    res_d.count   = CNTF_W'(cnt_d);
    res_d.last    = 1'b1;
    if (ctl_i.disp_step) begin
      res_d.status  = ST_OK;
      res_d.element = ELEM_W'(cells_q[0]);
      res_d.count   = CNTF_W'(cnt_q);
      res_d.last    = disp_last;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q   <= '0;
      idx_q   <= '0;
      valid_q <= 1'b0;
    end else begin
      cnt_q   <= cnt_d;
      idx_q   <= idx_d;
      valid_q <= ctl_i.exec || ctl_i.disp_step;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q   <= res_d;
    cells_q <= cells_d;
  end

  assign res_valid_o = valid_q;
  assign res_o       = res_q;

endmodule

// ----- sv/positional_insert_delete_list_core.sv -----
// Ordered list of up to CAPACITY signed words with positional insert and delete.
// Command channel: a word on cmd_i (command, position, value) is taken at a
// rising edge where start is high and busy is low.
// Result channel: each result word appears on res_o for exactly one cycle with
// res_valid_o high; the receiver cannot stall it and must take it then.
// Insert, delete and unused codes give one result, registered at the edge
// that takes the command; busy stays low, so a new command may follow in the
// next cycle. Display of a list of n > 0 words raises busy while it runs and
// gives n result words, one a cycle from the display state, with last set on
// the final one; display of an empty list gives one result like an insert.
// The cell row shifts every word behind the insert or delete point at once;
// display walks the row by rotating it, one word per cycle, as display time.
// Reset clears the element count and the display pointer; cell contents are
// undefined until written, and only cells below the count are ever shown.
module positional_insert_delete_list_core import pidl_pkg::*; #(
  parameter int unsigned CAPACITY   = CAPACITY_DEF,
  parameter int unsigned DATA_WIDTH = DATA_WIDTH_DEF
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      start,
  output logic      busy,
  input  pidl_in_t  cmd_i,
  output logic      res_valid_o,
  output pidl_out_t res_o
);

  pidl_ctl_t ctl;
  pidl_sts_t sts;

  pidl_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start     (start),
    .command_i (cmd_i.command),
    .sts_i     (sts),
    .busy      (busy),
    .ctl_o     (ctl)
  );

  pidl_datapath #(
    .CAPACITY   (CAPACITY),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd_i),
    .ctl_i       (ctl),
    .sts_o       (sts),
    .res_valid_o (res_valid_o),
    .res_o       (res_o)
  );

endmodule
